FILE: rtl/hssa_pkg.sv
// Package for the stack slot allocator: request and response types,
// status and operation codes, fixed field widths. No dependencies.

package hssa_pkg;

    localparam int SLOT_W = 15;
    localparam int LINK_W = 16;
    localparam int CFG_W  = 3;
    localparam int PAGE_W = 2;
    localparam int STAT_W = 3;

    localparam logic [CFG_W-1:0] DIR_COUNT_RESET = 3'd4;

    localparam logic OP_RESERVE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STAT_W-1:0] ST_DIR_FAIL   = 3'd2;
    localparam logic [STAT_W-1:0] ST_TABLE_FAIL = 3'd3;
    localparam logic [STAT_W-1:0] ST_RELEASED   = 3'd4;

    typedef struct packed {
        logic              op;
        logic [SLOT_W-1:0] slot_index;
        logic [PAGE_W-1:0] pages_available;
    } t_req;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic [STAT_W-1:0] status;
    } t_rsp;

endpackage

FILE: rtl/hierarchical_stack_slot_allocator.sv
// Top level of the stack slot allocator: control sequencer around the
// slot link memory. Depends on hssa_pkg and hssa_ram.
//
//   channel   | valid / strobe | ready / busy | payload
//   ----------+----------------+--------------+------------
//   request   | start          | busy         | i_req
//   response  | o_done         | (none)       | o_rsp
//   config    | i_cfg_valid    | o_cfg_ready  | i_cfg_data
//
// A release, and a reserve that ends in an error, shows its result in the cycle
// after acceptance. A reserve from a non-empty free list goes through S_RD and
// S_WT: one read of the link memory, then its registered read data. A refill adds
// one link write per slot of the new table (16 at default sizes) before that read.
// The link memory has a single write port; that port sets the refill time.
// Reset clears the control state only; the link memory needs no clearing.
// Results are strobed for one cycle and cannot be stalled.

module hierarchical_stack_slot_allocator
    import hssa_pkg::*;
#(
    parameter int MAX_DIRECTORIES   = 4,
    parameter int ENTRIES_PER_TABLE = 512,
    parameter int PAGES_PER_SLOT    = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_done,
    output t_rsp             o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int SLOTS_PER_TABLE = (ENTRIES_PER_TABLE / PAGES_PER_SLOT) > 0 ?
                                     (ENTRIES_PER_TABLE / PAGES_PER_SLOT) : 1;
    localparam int NDW  = $clog2(MAX_DIRECTORIES + 1);
    localparam int CDW  = MAX_DIRECTORIES > 1 ? $clog2(MAX_DIRECTORIES) : 1;
    localparam int NTW  = $clog2(ENTRIES_PER_TABLE + 1);
    localparam int FIW  = SLOTS_PER_TABLE > 1 ? $clog2(SLOTS_PER_TABLE) : 1;
    localparam int CMPW = NDW > CFG_W ? NDW : CFG_W;
    localparam int DEPTH = 1 << SLOT_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_RD   = 4'b0100,
        S_WT   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_dir_count, n_dir_count;
    logic [SLOT_W-1:0] r_head, n_head;
    logic              r_head_valid, n_head_valid;
    logic [NDW-1:0]    r_next_dir, n_next_dir;
    logic [CDW-1:0]    r_cur_dir, n_cur_dir;
    logic [NTW-1:0]    r_next_table, n_next_table;
    logic [SLOT_W-1:0] r_base, n_base;
    logic [FIW-1:0]    r_fill_idx, n_fill_idx;
    logic              r_done, n_done;
    t_rsp              r_rsp, n_rsp;

    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    logic [LINK_W-1:0] w_wdata;
    logic [LINK_W-1:0] w_rdata;

    logic              w_accept;
    logic [CMPW-1:0]   w_cnt_ext, w_max_ext, w_limit;
    logic              w_need_dir, w_region_full, w_last_fill;
    logic [PAGE_W-1:0] w_pages_left;
    logic [CDW-1:0]    w_dir;
    logic [NTW-1:0]    w_table;
    logic [31:0]       w_base_full;
    logic [SLOT_W-1:0] w_fill_addr;

    hssa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (DEPTH)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    assign w_accept  = start && !busy;
    assign w_cnt_ext = CMPW'(r_dir_count);
    assign w_max_ext = CMPW'(MAX_DIRECTORIES);
    assign w_limit   = (w_cnt_ext > w_max_ext) ? w_max_ext : w_cnt_ext;

    assign w_need_dir    = r_next_table >= NTW'(ENTRIES_PER_TABLE);
    assign w_region_full = CMPW'(r_next_dir) >= w_limit;

    // Directory page is spent first, then the table page.
    assign w_pages_left = w_need_dir ? (i_req.pages_available - PAGE_W'(1))
                                     : i_req.pages_available;
    assign w_dir        = w_need_dir ? r_next_dir[CDW-1:0] : r_cur_dir;
    assign w_table      = w_need_dir ? '0 : r_next_table;
    assign w_base_full  = (32'(w_dir) * 32'(ENTRIES_PER_TABLE) + 32'(w_table))
                          * 32'(SLOTS_PER_TABLE);

    assign w_last_fill = r_fill_idx == FIW'(SLOTS_PER_TABLE - 1);
    assign w_fill_addr = r_base + SLOT_W'(r_fill_idx);

    always_comb begin
        n_state      = r_state;
        n_dir_count  = r_dir_count;
        n_head       = r_head;
        n_head_valid = r_head_valid;
        n_next_dir   = r_next_dir;
        n_cur_dir    = r_cur_dir;
        n_next_table = r_next_table;
        n_base       = r_base;
        n_fill_idx   = r_fill_idx;
        n_done       = 1'b0;
        n_rsp        = r_rsp;
        w_we         = 1'b0;
        w_waddr      = w_fill_addr;
        w_wdata      = '0;

        if (i_cfg_valid) begin
            n_dir_count = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_rsp = '{granted: 1'b0, slot: '0, status: ST_OK};
                    if (i_req.op == OP_RELEASE) begin
                        w_we         = 1'b1;
                        w_waddr      = i_req.slot_index;
                        w_wdata      = r_head_valid ? {1'b1, r_head} : '0;
                        n_head       = i_req.slot_index;
                        n_head_valid = 1'b1;
                        n_done       = 1'b1;
                        n_rsp.status = ST_RELEASED;
                    end else if (r_head_valid) begin
                        n_state = S_RD;
                    end else if (w_need_dir && w_region_full) begin
                        n_done       = 1'b1;
                        n_rsp.status = ST_FULL;
                    end else if (w_need_dir && i_req.pages_available == '0) begin
                        // Directory is taken and lost
                        n_next_dir   = r_next_dir + NDW'(1);
                        n_done       = 1'b1;
                        n_rsp.status = ST_DIR_FAIL;
                    end else begin
                        if (w_need_dir) begin
                            n_next_dir = r_next_dir + NDW'(1);
                            n_cur_dir  = w_dir;
                        end
                        n_next_table = w_table + NTW'(1);
                        if (w_pages_left == '0) begin
                            n_done       = 1'b1;
                            n_rsp.status = ST_TABLE_FAIL;
                        end else begin
                            n_base     = w_base_full[SLOT_W-1:0];
                            n_fill_idx = '0;
                            n_state    = S_FILL;
                        end
                    end
                end
            end
            S_FILL: begin
                // Chain the new table's slots in ascending order
                w_we    = 1'b1;
                w_waddr = w_fill_addr;
                w_wdata = w_last_fill ? '0 : {1'b1, w_fill_addr + SLOT_W'(1)};
                n_fill_idx = r_fill_idx + FIW'(1);
                if (w_last_fill) begin
                    n_head       = r_base;
                    n_head_valid = 1'b1;
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                n_state = S_WT;
            end
            S_WT: begin
                if (w_rdata[LINK_W-1]) begin
                    n_head = w_rdata[SLOT_W-1:0];
                end else begin
                    n_head_valid = 1'b0;
                end
                n_done  = 1'b1;
                n_rsp   = '{granted: 1'b1, slot: r_head, status: ST_OK};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dir_count  <= DIR_COUNT_RESET;
            r_head       <= '0;
            r_head_valid <= 1'b0;
            r_next_dir   <= '0;
            r_cur_dir    <= '0;
            r_next_table <= NTW'(ENTRIES_PER_TABLE);
            r_fill_idx   <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_dir_count  <= n_dir_count;
            r_head       <= n_head;
            r_head_valid <= n_head_valid;
            r_next_dir   <= n_next_dir;
            r_cur_dir    <= n_cur_dir;
            r_next_table <= n_next_table;
            r_fill_idx   <= n_fill_idx;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_rsp  <= n_rsp;
    end

    assign busy        = r_state != S_IDLE;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: rtl/hssa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.

module hssa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sim/hssa_checker.sv
// Scoreboard for the stack slot allocator: tracks free list, table and directory
// state, predicts every response and compares it with the strobed result.
// Depends on hssa_pkg.
`timescale 1ns / 100ps

module hssa_checker
    import hssa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  t_req             i_req,
    input  logic             i_done,
    input  t_rsp             i_rsp,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_errors,
    output int               o_pending,
    output int               o_grants,
    output int               o_full,
    output int               o_page_fails,
    output int               o_releases
);

    localparam int MAX_DIRS        = 4;
    localparam int TABLES_PER_DIR  = 512;
    localparam int PAGES_PER_SLOT  = 32;
    localparam int SLOTS_PER_TABLE = (TABLES_PER_DIR / PAGES_PER_SLOT) > 0 ?
                                     (TABLES_PER_DIR / PAGES_PER_SLOT) : 1;

    logic [LINK_W-1:0] link_mem [0:32767];
    logic [SLOT_W-1:0] head_slot;
    logic              head_ok;
    int                dirs_taken;
    int                dir_in_use;
    int                next_tbl;
    logic [CFG_W-1:0]  dir_count;

    t_rsp              rsp_expected [$];

    // Advance the allocator state by one request and return its response.
    function automatic t_rsp slot_outcome(t_req r);
        t_rsp              res;
        int                pages;
        int                lim;
        int                tbl;
        int                base_i;
        logic [SLOT_W-1:0] here;
        logic [LINK_W-1:0] link;
        res   = '0;
        pages = r.pages_available;
        if (r.op == OP_RELEASE) begin
            link_mem[r.slot_index] = head_ok ? {1'b1, head_slot} : '0;
            head_slot  = r.slot_index;
            head_ok    = 1'b1;
            res.status = ST_RELEASED;
            return res;
        end
        if (!head_ok) begin
            if (next_tbl >= TABLES_PER_DIR) begin
                lim = (dir_count > MAX_DIRS) ? MAX_DIRS : int'(dir_count);
                if (dirs_taken >= lim) begin
                    res.status = ST_FULL;
                    return res;
                end
                dirs_taken = dirs_taken + 1;
                // the directory is gone even when its page is missing
                if (pages == 0) begin
                    res.status = ST_DIR_FAIL;
                    return res;
                end
                pages      = pages - 1;
                dir_in_use = dirs_taken - 1;
                next_tbl   = 0;
            end
            tbl      = next_tbl;
            next_tbl = next_tbl + 1;
            if (pages == 0) begin
                res.status = ST_TABLE_FAIL;
                return res;
            end
            base_i = ((dir_in_use * TABLES_PER_DIR + tbl) * SLOTS_PER_TABLE) & 32'h7fff;
            // chain the new table in ascending order
            for (int i = 0; i < SLOTS_PER_TABLE; i++) begin
                here = SLOT_W'(base_i + i);
                if (i + 1 < SLOTS_PER_TABLE)
                    link_mem[here] = {1'b1, SLOT_W'(base_i + i + 1)};
                else
                    link_mem[here] = '0;
            end
            head_slot = SLOT_W'(base_i);
            head_ok   = 1'b1;
        end
        link = link_mem[head_slot];
        res.granted = 1'b1;
        res.slot    = head_slot;
        res.status  = ST_OK;
        if (link[LINK_W-1])
            head_slot = link[SLOT_W-1:0];
        else
            head_ok = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            head_slot  = '0;
            head_ok    = 1'b0;
            dirs_taken = 0;
            dir_in_use = 0;
            next_tbl   = TABLES_PER_DIR;
            dir_count  = DIR_COUNT_RESET;
            rsp_expected.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                dir_count = i_cfg_data;
            if (i_done) begin
                case (i_rsp.status)
                    ST_OK:                     o_grants++;
                    ST_FULL:                   o_full++;
                    ST_DIR_FAIL, ST_TABLE_FAIL: o_page_fails++;
                    ST_RELEASED:               o_releases++;
                    default: ;
                endcase
                // fields are printed as granted/slot/status
                if (rsp_expected.size() == 0) begin
                    o_errors++;
                    $display("%0t: result with no request outstanding: %0d/%0d/%0d",
                             $time, i_rsp.granted, i_rsp.slot, i_rsp.status);
                end else begin
                    want = rsp_expected.pop_front();
                    if (i_rsp.granted !== want.granted || i_rsp.slot !== want.slot ||
                        i_rsp.status !== want.status) begin
                        o_errors++;
                        $display("%0t: mismatch, expected %0d/%0d/%0d actual %0d/%0d/%0d",
                                 $time, want.granted, want.slot, want.status,
                                 i_rsp.granted, i_rsp.slot, i_rsp.status);
                    end
                end
            end
            if (i_start && !i_busy)
                rsp_expected.push_back(slot_outcome(i_req));
        end
        o_pending = rsp_expected.size();
    end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the stack slot allocator: clock, reset, request and
// directory-count stimulus, verdict. Depends on hssa_pkg, hssa_checker and the allocator top.
`timescale 1ns / 100ps

module tb_top;
    import hssa_pkg::*;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_req             i_req       = '0;
    logic             o_done;
    t_rsp             o_rsp;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    int errors;
    int pending;
    int grants;
    int fulls;
    int page_fails;
    int releases;
    int n_items = 0;
    int n_cfg   = 0;

    // stimulus bookkeeping: slots handed out, and slots sitting on the free list
    logic [SLOT_W-1:0] held_slots [$];
    bit                on_free_list [0:32767];

    hierarchical_stack_slot_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    hssa_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_done       (o_done),
        .i_rsp        (o_rsp),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_grants     (grants),
        .o_full       (fulls),
        .o_page_fails (page_fails),
        .o_releases   (releases)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_done && o_rsp.granted) begin
            on_free_list[o_rsp.slot] = 1'b0;
            held_slots.push_back(o_rsp.slot);
        end
    end

    // Hold the request until the block takes it.
    task automatic issue(input t_req r);
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        n_items++;
    endtask

    task automatic reserve(input int pages);
        t_req r;
        r.op              = OP_RESERVE;
        r.slot_index      = SLOT_W'($urandom_range(32767));
        r.pages_available = PAGE_W'(pages);
        issue(r);
    endtask

    task automatic release_slot(input logic [SLOT_W-1:0] s);
        t_req r;
        r.op              = OP_RELEASE;
        r.slot_index      = s;
        r.pages_available = PAGE_W'($urandom_range(3));
        on_free_list[s]   = 1'b1;
        issue(r);
    endtask

    task automatic sender_gap(input int pct);
        if (pct > 0 && $urandom_range(99) < pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < pct);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_dir_count(input logic [CFG_W-1:0] v);
        wait_drained();
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // A reserve or, by release_pct, a release: mostly of slots that were handed out,
    // the rest stray slots in the top directory. Skip anything already on the free list
    // to keep it acyclic (the item stays a reserve), so refills stay reachable.
    task automatic random_item(input int release_pct, input int zero_pct);
        t_req              r;
        int                idx;
        logic [SLOT_W-1:0] s;
        r.op              = OP_RESERVE;
        r.slot_index      = SLOT_W'($urandom_range(32767));
        r.pages_available = ($urandom_range(99) < zero_pct) ? '0 :
                            PAGE_W'($urandom_range(1, 3));
        if ($urandom_range(99) < release_pct) begin
            if (held_slots.size() != 0 && $urandom_range(99) < 75) begin
                idx = $urandom_range(held_slots.size() - 1);
                s   = held_slots[idx];
                held_slots.delete(idx);
            end else begin
                s = {2'b11, 13'($urandom_range(8191))};
            end
            if (!on_free_list[s]) begin
                r.op            = OP_RELEASE;
                r.slot_index    = s;
                on_free_list[s] = 1'b1;
            end
        end
        issue(r);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] dir_cfg, input int count,
                             input int idle_pct, input int release_pct,
                             input int zero_pct, input bit pause_mid);
        write_dir_count(dir_cfg);
        for (int k = 0; k < count; k++) begin
            if (pause_mid && k == count / 2)
                wait_drained();
            sender_gap(idle_pct);
            random_item(release_pct, zero_pct);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no directories at all: every refill reports region full
        write_dir_count(3'd0);
        reserve(3);
        release_slot(15'h7fff);
        reserve(0);
        reserve(2);

        // count above the maximum; lose directory 0, then a table of directory 1
        write_dir_count(3'd7);
        reserve(0);
        reserve(1);
        reserve(2);
        reserve(3);
        release_slot(15'h0000);
        release_slot(15'd8208);
        reserve(0);
        reserve(0);
        reserve(1);
        release_slot(15'd8210);
        reserve(0);

        run_phase(3'd4, 150, 0,  40, 15, 1'b0);
        run_phase(3'd1, 150, 72, 40, 15, 1'b0);
        run_phase(3'd3, 150, 9,  40, 15, 1'b0);
        // burn through the remaining tables so directories roll over and run out
        run_phase(3'd7, 560, 0,  2,  100, 1'b0);
        run_phase(3'd2, 150, 72, 45, 15, 1'b0);
        run_phase(3'd4, 100, 0,  45, 15, 1'b1);

        // double release last: it turns the free list into a loop on one slot
        wait_drained();
        release_slot(15'd5);
        release_slot(15'd5);
        reserve(0);
        reserve(2);
        reserve(3);

        wait_drained();
        repeat (25) @(posedge i_clk);
        $display("covered %0d requests and %0d directory-count writes over six traffic phases",
                 n_items, n_cfg);
        $display("responses: %0d grants, %0d region full, %0d page failures, %0d releases",
                 grants, fulls, page_fails, releases);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
